### sv/tbp_pkg.sv
// Package for the tournament branch predictor: item kinds, queue entry type,
// counter constants and the saturating counter helper. No dependencies.
`default_nettype none

package tbp_pkg;

  // Input item kinds
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

  // 2-bit counter values
  localparam logic [1:0] CTR_MAX       = 2'd3;
  localparam logic [1:0] CTR_MIN       = 2'd0;
  localparam logic [1:0] CTR_RESET     = 2'd2;
  localparam logic [1:0] CHOOSER_RESET = 2'd1;

  localparam int PC_BITS   = 32;
  localparam int QUEUE_CAP = 2;

  // Classified item held in the queue between front and back
  typedef struct packed {
    logic                 is_update;
    logic                 taken;
    logic [PC_BITS-1:0]   pc;
  } item_t;

  // Saturating 2-bit counter step
  function automatic logic [1:0] ctr_move(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/tbp_in_if.sv
// Input channel of the branch predictor: valid/ready plus the item fields.
// No dependencies.
`default_nettype none

interface tbp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] pc;
  logic        taken_outcome;

  modport source (output valid, kind, pc, taken_outcome, input ready);
  modport sink   (input valid, kind, pc, taken_outcome, output ready);
endinterface

`default_nettype wire

### sv/tbp_out_if.sv
// Output channel of the branch predictor: valid/ready plus the prediction.
// No dependencies.
`default_nettype none

interface tbp_out_if;
  logic valid;
  logic ready;
  logic predicted_taken;

  modport source (output valid, predicted_taken, input ready);
  modport sink   (input valid, predicted_taken, output ready);
endinterface

`default_nettype wire

### sv/tbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/tbp_front.sv
// Front end: accepts input transfers, classifies them and queues them for
// the back end. Depends on tbp_pkg and tbp_in_if.
`default_nettype none

module tbp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  tbp_in_if.sink             in_ch,
  input  wire logic          pop,
  output      logic          q_valid,
  output      tbp_pkg::item_t q_item
);

  localparam int CNT_W = $clog2(tbp_pkg::QUEUE_CAP + 1);
  localparam int PTR_W = $clog2(tbp_pkg::QUEUE_CAP);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(tbp_pkg::QUEUE_CAP);

  tbp_pkg::item_t    q_mem [tbp_pkg::QUEUE_CAP];
  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic              push;
  logic              do_pop;
  tbp_pkg::item_t    new_item;

  assign in_ch.ready = (count != FULL);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign do_pop      = pop && q_valid;
  assign q_item      = q_mem[rd_ptr];

  // Classify the incoming item
  always_comb begin
    new_item.is_update = (in_ch.kind == tbp_pkg::KIND_UPDATE);
    new_item.taken     = in_ch.taken_outcome;
    new_item.pc        = in_ch.pc;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= new_item;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/tbp_back.sv
// Back end: clearing pass, table lookups, prediction output register and
// counter/history updates. Depends on tbp_pkg, tbp_ram and tbp_out_if.
`default_nettype none

module tbp_back #(
  parameter int LOCAL_INDEX_BITS = 14,
  parameter int HISTORY_BITS     = 13
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire tbp_pkg::item_t q_item,
  output      logic           pop,
  tbp_out_if.source           out_ch
);

  localparam int LH_DEPTH  = 1 << LOCAL_INDEX_BITS;
  localparam int CTR_DEPTH = 1 << HISTORY_BITS;
  localparam int CLR_W     = (LOCAL_INDEX_BITS > HISTORY_BITS) ?
                             LOCAL_INDEX_BITS : HISTORY_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LC,
    ST_EXEC
  } state_t;

  state_t                       state;
  logic [CLR_W-1:0]             clr_idx;
  logic [HISTORY_BITS-1:0]      ghist;
  logic [HISTORY_BITS-1:0]      cur_gidx;
  logic [LOCAL_INDEX_BITS-1:0]  cur_lhidx;
  logic                         cur_update;
  logic                         cur_taken;
  logic                         out_valid;
  logic                         out_pred;

  logic [HISTORY_BITS-1:0]      issue_gidx;
  logic [LOCAL_INDEX_BITS-1:0]  issue_lhidx;
  logic [HISTORY_BITS-1:0]      lht_rdata;
  logic [1:0]                   lc_rdata;
  logic [1:0]                   gs_rdata;
  logic [1:0]                   ch_rdata;

  logic                         clearing;
  logic                         exec_upd;
  logic                         exec_pred;
  logic                         out_free;
  logic                         gpred;
  logic                         lpred;
  logic                         final_pred;

  logic                         lht_we;
  logic [LOCAL_INDEX_BITS-1:0]  lht_waddr;
  logic [HISTORY_BITS-1:0]      lht_wdata;
  logic                         ctr_we;
  logic                         ch_we;
  logic [HISTORY_BITS-1:0]      lc_waddr;
  logic [HISTORY_BITS-1:0]      g_waddr;
  logic [1:0]                   lc_wdata;
  logic [1:0]                   gs_wdata;
  logic [1:0]                   ch_wdata;

  assign out_ch.valid           = out_valid;
  assign out_ch.predicted_taken = out_pred;

  // Lookup addresses for the item at the queue head
  assign pop         = (state == ST_IDLE) && q_valid;
  assign issue_gidx  = q_item.pc[HISTORY_BITS-1:0] ^ ghist;
  assign issue_lhidx = q_item.pc[LOCAL_INDEX_BITS-1:0];

  // Predictions from the read data
  assign gpred      = gs_rdata[1];
  assign lpred      = lc_rdata[1];
  assign final_pred = ch_rdata[1] ? gpred : lpred;
  assign out_free   = !out_valid || out_ch.ready;

  assign clearing  = (state == ST_CLEAR);
  assign exec_upd  = (state == ST_EXEC) && cur_update;
  assign exec_pred = (state == ST_EXEC) && !cur_update;

  // Write side: clearing pass or update
  always_comb begin
    lht_we    = clearing || exec_upd;
    ctr_we    = clearing || exec_upd;
    ch_we     = clearing || (exec_upd && (gpred != lpred));
    lht_waddr = clearing ? clr_idx[LOCAL_INDEX_BITS-1:0] : cur_lhidx;
    lc_waddr  = clearing ? clr_idx[HISTORY_BITS-1:0] : lht_rdata;
    g_waddr   = clearing ? clr_idx[HISTORY_BITS-1:0] : cur_gidx;
    lht_wdata = clearing ? '0 : {lht_rdata[HISTORY_BITS-2:0], cur_taken};
    lc_wdata  = clearing ? tbp_pkg::CTR_RESET :
                tbp_pkg::ctr_move(lc_rdata, cur_taken);
    gs_wdata  = clearing ? tbp_pkg::CTR_RESET :
                tbp_pkg::ctr_move(gs_rdata, cur_taken);
    ch_wdata  = clearing ? tbp_pkg::CHOOSER_RESET :
                tbp_pkg::ctr_move(ch_rdata, cur_taken == gpred);
  end

  // Local history table
  tbp_ram #(.WIDTH(HISTORY_BITS), .DEPTH(LH_DEPTH)) u_lht (
    .clk   (clk),
    .we    (lht_we),
    .waddr (lht_waddr),
    .wdata (lht_wdata),
    .re    (pop),
    .raddr (issue_lhidx),
    .rdata (lht_rdata)
  );

  // Local counters, read with the local history
  tbp_ram #(.WIDTH(2), .DEPTH(CTR_DEPTH)) u_lc (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .re    (state == ST_LC),
    .raddr (lht_rdata),
    .rdata (lc_rdata)
  );

  // Gshare counters
  tbp_ram #(.WIDTH(2), .DEPTH(CTR_DEPTH)) u_gs (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (g_waddr),
    .wdata (gs_wdata),
    .re    (pop),
    .raddr (issue_gidx),
    .rdata (gs_rdata)
  );

  // Chooser counters
  tbp_ram #(.WIDTH(2), .DEPTH(CTR_DEPTH)) u_ch (
    .clk   (clk),
    .we    (ch_we),
    .waddr (g_waddr),
    .wdata (ch_wdata),
    .re    (pop),
    .raddr (issue_gidx),
    .rdata (ch_rdata)
  );

  // Item held while it is worked on
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_gidx   <= issue_gidx;
      cur_lhidx  <= issue_lhidx;
      cur_update <= q_item.is_update;
      cur_taken  <= q_item.taken;
    end
  end

  // Sequencer and global history
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      ghist   <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + CLR_W'(1);
          if (clr_idx == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) state <= ST_LC;
        end
        ST_LC: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (cur_update) begin
            ghist <= {ghist[HISTORY_BITS-2:0], cur_taken};
            state <= ST_IDLE;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Prediction output register, loaded when free, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_pred  <= 1'b0;
    end else if (exec_pred && out_free) begin
      out_valid <= 1'b1;
      out_pred  <= final_pred;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/tournament_branch_predictor_top.sv
// Tournament branch predictor (gshare plus local history), top level.
// After reset the block runs a clearing pass over every index below
// 2**max(LOCAL_INDEX_BITS, HISTORY_BITS) that loads the counter tables and
// the local history table; items are queued but not worked on until it
// ends. The back end then takes one item at a time: its pop reads the local
// history, gshare and chooser tables, state ST_LC reads the local counter
// selected by that history, and state ST_EXEC forms the prediction, waiting
// while the output register is full, or writes the updated counters and
// histories. A two-entry queue at the input accepts transfers while the back
// end works, until full, and an output register holds a prediction until taken.
// Depends on tbp_pkg, tbp_in_if, tbp_out_if, tbp_front and tbp_back.
`default_nettype none

module tournament_branch_predictor_top #(
  parameter int LOCAL_INDEX_BITS = 14,
  parameter int HISTORY_BITS     = 13
) (
  input  wire logic clk,
  input  wire logic rst,
  tbp_in_if.sink    in_ch,
  tbp_out_if.source out_ch
);

  logic           q_valid;
  logic           pop;
  tbp_pkg::item_t q_item;

  // Accept and queue items
  tbp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .pop     (pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // Tables and sequencing
  tbp_back #(
    .LOCAL_INDEX_BITS (LOCAL_INDEX_BITS),
    .HISTORY_BITS     (HISTORY_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

### tb/tbp_checker.sv
// Checker for the tournament branch predictor: keeps its own gshare, local and
// chooser tables, predicts every result and compares it on the output channel.
// Depends on tbp_pkg, tbp_in_if and tbp_out_if.

module tbp_checker #(
  parameter int LOCAL_INDEX_BITS = 14,
  parameter int HISTORY_BITS     = 13
) (
  input  logic        clk,
  input  logic        rst,
  tbp_in_if           in_ch,
  tbp_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned expected_left,
  output int unsigned predicts_seen,
  output int unsigned updates_seen,
  output int unsigned results_checked
);

  localparam int LH_DEPTH  = 1 << LOCAL_INDEX_BITS;
  localparam int CTR_DEPTH = 1 << HISTORY_BITS;

  // Mirrored predictor state
  logic [HISTORY_BITS-1:0] ghist;
  logic [HISTORY_BITS-1:0] lhist_tbl   [LH_DEPTH];
  logic [1:0]              local_ctr   [CTR_DEPTH];
  logic [1:0]              gshare_ctr  [CTR_DEPTH];
  logic [1:0]              chooser_ctr [CTR_DEPTH];

  // Predictions waiting for their output transfer, oldest first
  logic        pending_taken_q[$];
  logic        want_taken;
  int unsigned fails, n_predict, n_update, n_checked;

  function automatic logic [1:0] sat_step(input logic [1:0] v, input logic up);
    if (up) return (v == tbp_pkg::CTR_MAX) ? v : v + 2'd1;
    return (v == tbp_pkg::CTR_MIN) ? v : v - 2'd1;
  endfunction

  task automatic clear_tables();
    ghist = '0;
    foreach (lhist_tbl[i]) lhist_tbl[i] = '0;
    for (int i = 0; i < CTR_DEPTH; i++) begin
      local_ctr[i]   = tbp_pkg::CTR_RESET;
      gshare_ctr[i]  = tbp_pkg::CTR_RESET;
      chooser_ctr[i] = tbp_pkg::CHOOSER_RESET;
    end
  endtask

  // One accepted input: predict pushes an expectation, update trains tables
  task automatic absorb_item(input logic kind, input logic [31:0] pc, input logic taken);
    logic [HISTORY_BITS-1:0]     g_idx;
    logic [HISTORY_BITS-1:0]     lc_idx;
    logic [LOCAL_INDEX_BITS-1:0] lh_idx;
    logic                        g_pred;
    logic                        l_pred;
    g_idx  = pc[HISTORY_BITS-1:0] ^ ghist;
    lh_idx = pc[LOCAL_INDEX_BITS-1:0];
    lc_idx = lhist_tbl[lh_idx];
    g_pred = gshare_ctr[g_idx][1];
    l_pred = local_ctr[lc_idx][1];
    if (kind == tbp_pkg::KIND_PREDICT) begin
      pending_taken_q.push_back(chooser_ctr[g_idx][1] ? g_pred : l_pred);
      n_predict++;
    end else begin
      // chooser only moves when the two sides disagree
      if (g_pred != l_pred)
        chooser_ctr[g_idx] = sat_step(chooser_ctr[g_idx], taken == g_pred);
      local_ctr[lc_idx] = sat_step(local_ctr[lc_idx], taken);
      gshare_ctr[g_idx] = sat_step(gshare_ctr[g_idx], taken);
      lhist_tbl[lh_idx] = {lhist_tbl[lh_idx][HISTORY_BITS-2:0], taken};
      ghist             = {ghist[HISTORY_BITS-2:0], taken};
      n_update++;
    end
  endtask

  initial begin
    fails     = 0;
    n_predict = 0;
    n_update  = 0;
    n_checked = 0;
  end

  // Compare outgoing transfers first, then fold in the incoming one
  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      pending_taken_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_taken_q.size() == 0) begin
          $error("predicted_taken: expected nothing, actual %0d", out_ch.predicted_taken);
          fails++;
        end else begin
          want_taken = pending_taken_q.pop_front();
          n_checked++;
          if (out_ch.predicted_taken !== want_taken) begin
            $error("predicted_taken: expected %0d, actual %0d", want_taken,
                   out_ch.predicted_taken);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        absorb_item(in_ch.kind, in_ch.pc, in_ch.taken_outcome);
    end
    fail_count      <= fails;
    expected_left   <= pending_taken_q.size();
    predicts_seen   <= n_predict;
    updates_seen    <= n_update;
    results_checked <= n_checked;
  end

endmodule

### tb/testbench.sv
// Top of the branch predictor testbench: clock, reset, stimulus, receiver
// backpressure, watchdog and verdict. Depends on tbp_pkg, tbp_in_if,
// tbp_out_if, tournament_branch_predictor_top and tbp_checker.

module testbench;

  localparam int WATCHDOG_LIMIT     = 50000;  // covers the post-reset table clear
  localparam int RANDOM_ITEMS       = 825;
  localparam int HOT_BRANCHES       = 8;
  localparam int LOCAL_INDEX_BITS_W = 14;

  logic clk = 1'b0;
  logic rst;

  tbp_in_if  in_ch();
  tbp_out_if out_ch();

  int unsigned fail_count, expected_left, predicts_seen, updates_seen, results_checked;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent_items    = 0;
  int unsigned stall_cycles  = 0;

  // Hot branch table: low index bits, loop trip count and iteration count
  logic [LOCAL_INDEX_BITS_W-1:0] hot_pc   [HOT_BRANCHES];
  int unsigned                   hot_trip [HOT_BRANCHES];
  int unsigned                   hot_iter [HOT_BRANCHES];

  tournament_branch_predictor_top uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tbp_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .expected_left   (expected_left),
    .predicts_seen   (predicts_seen),
    .updates_seen    (updates_seen),
    .results_checked (results_checked)
  );

  always #2 clk = ~clk;

  // Receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item, with a random gap ahead of it; valid stays high after
  task automatic send_item(input logic kind, input logic [31:0] pc, input logic taken);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.pc            <= pc;
    in_ch.taken_outcome <= taken;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // Stop sending and hold off until every prediction has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  task automatic run_directed();
    send_item(tbp_pkg::KIND_PREDICT, 32'h0000_0000, 1'b0);
    send_item(tbp_pkg::KIND_PREDICT, 32'hFFFF_FFFF, 1'b1);   // outcome ignored on predict
    send_item(tbp_pkg::KIND_UPDATE,  32'hFFFF_FFFF, 1'b1);
    send_item(tbp_pkg::KIND_PREDICT, 32'hFFFF_FFFF, 1'b0);
    // repeated taken updates on one branch (the histories move the counter indices)
    repeat (4) send_item(tbp_pkg::KIND_UPDATE, 32'h0000_0005, 1'b1);
    send_item(tbp_pkg::KIND_PREDICT, 32'h0000_0005, 1'b0);
    // then repeated not-taken updates on it
    repeat (5) send_item(tbp_pkg::KIND_UPDATE, 32'h0000_0005, 1'b0);
    send_item(tbp_pkg::KIND_PREDICT, 32'h0000_0005, 1'b1);
    // upper pc bits alias onto the same entries
    send_item(tbp_pkg::KIND_UPDATE,  32'hABCD_0005, 1'b0);
    send_item(tbp_pkg::KIND_PREDICT, 32'hABCD_0005, 1'b0);
    // alternating outcome makes the two predictors disagree
    repeat (2) begin
      send_item(tbp_pkg::KIND_UPDATE,  32'h5555_AAAA, 1'b1);
      send_item(tbp_pkg::KIND_UPDATE,  32'h5555_AAAA, 1'b0);
      send_item(tbp_pkg::KIND_PREDICT, 32'h5555_AAAA, 1'b0);
    end
  endtask

  // Mostly predict/update pairs on hot branches with patterned outcomes
  task automatic random_burst(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned slot;
    logic [31:0] pc;
    logic        outcome;
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        slot = $urandom_range(HOT_BRANCHES - 1);
        pc = $urandom();
        pc[LOCAL_INDEX_BITS_W-1:0] = hot_pc[slot];
        case (slot % 4)
          0: outcome = (hot_iter[slot] % hot_trip[slot]) != hot_trip[slot] - 1;  // loop
          1: outcome = 1'b1;
          2: outcome = hot_iter[slot][0];
          default: outcome = 1'b0;
        endcase
        hot_iter[slot]++;
        send_item(tbp_pkg::KIND_PREDICT, pc, 1'($urandom_range(1)));
        send_item(tbp_pkg::KIND_UPDATE, pc, outcome);
      end else if (pick < 85) begin
        pc = $urandom();
        send_item(tbp_pkg::KIND_PREDICT, pc, 1'($urandom_range(1)));
        send_item(tbp_pkg::KIND_UPDATE, pc, 1'($urandom_range(1)));
      end else begin
        send_item(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= tbp_pkg::KIND_PREDICT;
    in_ch.pc            <= '0;
    in_ch.taken_outcome <= 1'b0;
    for (int i = 0; i < HOT_BRANCHES; i++) begin
      hot_pc[i]   = LOCAL_INDEX_BITS_W'($urandom());
      hot_trip[i] = $urandom_range(7, 3);
      hot_iter[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalling
    send_idle_pct = 25;
    recv_idle_pct = 74;
    run_directed();
    random_burst(RANDOM_ITEMS / 3);
    drain();

    // roles swapped
    send_idle_pct = 74;
    recv_idle_pct = 25;
    random_burst(RANDOM_ITEMS / 3);
    drain();

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(RANDOM_ITEMS / 3);
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d predict and %0d update transfers; %0d predictions compared",
             predicts_seen, updates_seen, results_checked);
    $display("across sender-heavy, receiver-heavy and unthrottled handshake profiles.");
    if (fail_count == 0 && expected_left == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/tbp_pkg.sv
sv/tbp_in_if.sv
sv/tbp_out_if.sv
sv/tbp_ram.sv
sv/tbp_front.sv
sv/tbp_back.sv
sv/tournament_branch_predictor_top.sv
tb/tbp_checker.sv
tb/testbench.sv
